// ----- design/dts_pkg.sv -----
package dts_pkg;

	localparam int STATE_BITS_DEF  = 6;
	localparam int SYMBOL_BITS_DEF = 8;
	localparam int OPCODE_W        = 3;

	typedef enum logic [OPCODE_W-1:0] {
		OP_STEP    = 3'd0,
		OP_ADD     = 3'd1,
		OP_CLEAR   = 3'd2,
		OP_RESTART = 3'd3,
		OP_HALT    = 3'd4,
		OP_PROBE   = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_HALT,
		ST_SWEEP
	} fsm_t;

endpackage

// ----- design/dts_if.sv -----
interface dts_req_if import dts_pkg::*; #(
	parameter int STATE_BITS  = STATE_BITS_DEF,
	parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [OPCODE_W-1:0]    opcode;
	logic [SYMBOL_BITS-1:0] symbol;
	logic [STATE_BITS-1:0]  from_state;
	logic [STATE_BITS-1:0]  to_state;
	logic                   halt_value;

	modport source (output valid, opcode, symbol, from_state, to_state, halt_value,
		input ready);
	modport sink (input valid, opcode, symbol, from_state, to_state, halt_value,
		output ready);
endinterface

interface dts_rsp_if import dts_pkg::*; #(
	parameter int STATE_BITS = STATE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [STATE_BITS-1:0] current_state_out;
	logic                  blocked_out;
	logic                  accepting;
	logic                  has_transition;

	modport source (output valid, current_state_out, blocked_out, accepting,
		has_transition, input ready);
	modport sink (input valid, current_state_out, blocked_out, accepting,
		has_transition, output ready);
endinterface

// ----- design/dts_ram.sv -----
module dts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- design/dfa_transition_table_stepper.sv -----
// Programmable table-driven automaton.
// req channel: one command per transfer (step, add transition, clear table,
// restart, set halt mark, probe). rsp channel: exactly one status transfer per
// command, in order: current state, blocked flag, accepting, probe result.
// cfg_we/cfg_wdata write the start state; write only while the block is idle.
// A command passes through ST_READ and ST_HALT, from which its result is
// registered onto rsp. A step reads the transition RAM at the state left by
// the previous step, then the halt RAM at the new state; the next command's
// table read overlaps the result cycle, so commands overlap unless rsp stalls.
// Clear table sweeps the transition RAM one entry a cycle, then passes
// through ST_READ and ST_HALT before its result.
// Reset: state 0, not blocked, start state 0. After arst_n rises a clearing
// pass over 2^(STATE_BITS+SYMBOL_BITS) entries (16384 by default) wipes both
// RAMs; req.ready stays low during it.
// Stall: one output register; a stalled rsp holds its result. A command taken
// from idle then waits in ST_HALT, req.ready low, until its result can go out.
module dfa_transition_table_stepper import dts_pkg::*; #(
	parameter int STATE_BITS  = STATE_BITS_DEF,
	parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [STATE_BITS-1:0] cfg_wdata,
	dts_req_if.sink               req,
	dts_rsp_if.source             rsp
);

	localparam int ADDR_W  = STATE_BITS + SYMBOL_BITS;
	localparam int DEPTH   = 1 << ADDR_W;
	localparam int H_DEPTH = 1 << STATE_BITS;
	localparam int ENTRY_W = STATE_BITS + 1;

	fsm_t                  state_q, state_d;
	op_t                   op_q;
	op_t                   req_op;
	logic [STATE_BITS-1:0] cur_q, cur_d, start_q;
	logic                  blocked_q, blocked_d;
	logic                  probe_q, probe_d;
	logic [ADDR_W-1:0]     sweep_cnt_q;
	logic                  rst_sweep_q;
	logic                  req_fire, out_load, result_load;

	logic                  out_valid_q;
	logic [STATE_BITS-1:0] out_state_q;
	logic                  out_blocked_q, out_accept_q, out_probe_q;

	logic                  st_wr_en;
	logic [ADDR_W-1:0]     st_wr_addr;
	logic [ENTRY_W-1:0]    st_wr_data, st_rd_data;
	logic                  h_wr_en, h_wr_data, h_rd_data;
	logic [STATE_BITS-1:0] h_wr_addr;

	assign req_op      = op_t'(req.opcode);
	assign out_load    = !out_valid_q || rsp.ready;
	assign result_load = (state_q == ST_HALT) && out_load;
	assign req.ready   = (state_q == ST_IDLE) || result_load;
	assign req_fire    = req.valid && req.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					state_d = (req_op == OP_CLEAR) ? ST_SWEEP : ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_HALT;
			end
			ST_HALT: begin
				if (req_fire) begin
					state_d = (req_op == OP_CLEAR) ? ST_SWEEP : ST_READ;
				end else if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			ST_SWEEP: begin
				if (sweep_cnt_q == ADDR_W'(DEPTH - 1)) begin
					state_d = rst_sweep_q ? ST_IDLE : ST_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cur_d     = cur_q;
		blocked_d = blocked_q;
		probe_d   = 1'b0;
		if (state_q == ST_READ) begin
			unique case (op_q)
				OP_STEP: begin
					if (!blocked_q) begin
						if (st_rd_data[STATE_BITS]) begin
							cur_d = st_rd_data[STATE_BITS-1:0];
						end else begin
							blocked_d = 1'b1;
						end
					end
				end
				OP_RESTART: begin
					cur_d     = start_q;
					blocked_d = 1'b0;
				end
				OP_PROBE: begin
					probe_d = !blocked_q && st_rd_data[STATE_BITS];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			op_q        <= OP_STEP;
			cur_q       <= '0;
			blocked_q   <= 1'b0;
			probe_q     <= 1'b0;
			start_q     <= '0;
			sweep_cnt_q <= '0;
			rst_sweep_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cur_q     <= cur_d;
			blocked_q <= blocked_d;
			if (state_q == ST_READ) begin
				probe_q <= probe_d;
			end
			if (cfg_we) begin
				start_q <= cfg_wdata;
			end
			if (req_fire) begin
				op_q        <= req_op;
				sweep_cnt_q <= '0;
			end else if (state_q == ST_SWEEP) begin
				sweep_cnt_q <= sweep_cnt_q + 1'b1;
				if (sweep_cnt_q == ADDR_W'(DEPTH - 1)) begin
					rst_sweep_q <= 1'b0;
				end
			end
			if (result_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			out_state_q   <= blocked_q ? '0 : cur_q;
			out_blocked_q <= blocked_q;
			out_accept_q  <= !blocked_q && h_rd_data;
			out_probe_q   <= probe_q;
		end
	end

	assign rsp.valid             = out_valid_q;
	assign rsp.current_state_out = out_state_q;
	assign rsp.blocked_out       = out_blocked_q;
	assign rsp.accepting         = out_accept_q;
	assign rsp.has_transition    = out_probe_q;

	// transition RAM: entry = {valid, next state}
	assign st_wr_en   = (state_q == ST_SWEEP) || (req_fire && req_op == OP_ADD);
	assign st_wr_addr = (state_q == ST_SWEEP) ? sweep_cnt_q : {req.from_state, req.symbol};
	assign st_wr_data = (state_q == ST_SWEEP) ? '0 : {1'b1, req.to_state};

	dts_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_trans_ram (
		.clk     (clk),
		.wr_en   (st_wr_en),
		.wr_addr (st_wr_addr),
		.wr_data (st_wr_data),
		.rd_en   (req_fire),
		.rd_addr ({cur_q, req.symbol}),
		.rd_data (st_rd_data)
	);

	// halt marks are wiped only by the reset pass
	assign h_wr_en   = ((state_q == ST_SWEEP) && rst_sweep_q) || (req_fire && req_op == OP_HALT);
	assign h_wr_addr = (state_q == ST_SWEEP) ? sweep_cnt_q[STATE_BITS-1:0] : req.from_state;
	assign h_wr_data = (state_q == ST_SWEEP) ? 1'b0 : req.halt_value;

	dts_ram #(
		.WIDTH (1),
		.DEPTH (H_DEPTH)
	) u_halt_ram (
		.clk     (clk),
		.wr_en   (h_wr_en),
		.wr_addr (h_wr_addr),
		.wr_data (h_wr_data),
		.rd_en   (state_q == ST_READ),
		.rd_addr (cur_d),
		.rd_data (h_rd_data)
	);

`ifndef NO_ASSERTIONS
	a_blocked_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.blocked_out |-> !rsp.accepting && !rsp.has_transition
			&& rsp.current_state_out == '0)
		else $error("blocked result carries live status");

	a_cmd_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && req_op != OP_CLEAR |=> state_q == ST_READ)
		else $error("accepted command did not start a table read");

	a_sweep_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		rst_sweep_q |-> !req.ready && !rsp.valid)
		else $error("command taken during reset clearing pass");

	a_probe_only: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ && op_q != OP_PROBE |=> !probe_q)
		else $error("probe result set by a non-probe command");
`endif

endmodule
